// File: rtl/core/ipv4_lpm_forwarder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the forwarder
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef IPV4_LPM_FORWARDER_TOP_ASSERT_SVH
`define IPV4_LPM_FORWARDER_TOP_ASSERT_SVH

// same-cycle implication
`define ILF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ilf_pkg.sv
// ----------------------------------------------------------------------------
// ilf_pkg
// Shared constants and types of the longest prefix match forwarder.
// ----------------------------------------------------------------------------
package ilf_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int MaxIfaces  = 16;

  localparam int AddrW  = 32;
  localparam int LenW   = 6;
  localparam int HopW   = 33;
  localparam int IfW    = 4;
  localparam int CfgW   = 5;
  localparam int TtlW   = 8;
  localparam int CsumW  = 16;

  localparam logic [CfgW-1:0] NumIfReset = 5'd16;
  localparam logic [LenW-1:0] FullLen    = 6'd32;

  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncRoute = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
    logic [HopW-1:0]  hop;
    logic [IfW-1:0]   iface;
  } entry_t;

  // best match so far, handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [LenW-1:0]  longest;
    logic [IfW-1:0]   iface;
    logic [HopW-1:0]  hop;
  } best_t;

endpackage

// File: rtl/core/ilf_if.sv
// ----------------------------------------------------------------------------
// ilf request and result channels
// Valid/ready channels carrying one request or one forwarding result.
// ----------------------------------------------------------------------------
interface ilf_req_if;
  import ilf_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [63:0]      hdr_front;
  logic [TtlW-1:0]  ttl;
  logic [7:0]       proto;
  logic [AddrW-1:0] src_addr;
  logic [AddrW-1:0] dest_ip;
  logic [AddrW-1:0] add_prefix;
  logic [LenW-1:0]  prefix_len;
  logic             has_gw;
  logic [AddrW-1:0] gw_ip;
  logic [IfW-1:0]   iface_num;

  modport source (
    output valid, func, hdr_front, ttl, proto, src_addr, dest_ip,
           add_prefix, prefix_len, has_gw, gw_ip, iface_num,
    input  ready
  );
  modport sink (
    input  valid, func, hdr_front, ttl, proto, src_addr, dest_ip,
           add_prefix, prefix_len, has_gw, gw_ip, iface_num,
    output ready
  );
endinterface

interface ilf_rsp_if;
  import ilf_pkg::*;

  logic             valid;
  logic             ready;
  logic [IfW-1:0]   out_iface;
  logic [AddrW-1:0] fwd_ip;
  logic [TtlW-1:0]  new_ttl;
  logic [CsumW-1:0] new_checksum;

  modport source (
    output valid, out_iface, fwd_ip, new_ttl, new_checksum,
    input  ready
  );
  modport sink (
    input  valid, out_iface, fwd_ip, new_ttl, new_checksum,
    output ready
  );
endinterface

// File: rtl/core/ipv4_lpm_forwarder_top.sv
// ----------------------------------------------------------------------------
// ipv4_lpm_forwarder_top
// Route table in a chain of cells with longest prefix match forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries requests. func=0 appends a route to the next free cell;
//   a full table ignores it. func=1 routes a header: a lookup token walks
//   the cell chain one cell per cycle, each cell keeping the best match so
//   far. The request is registered, then passes every cell register and a
//   pending register on its way to the output register; the next request
//   is taken once the result enters the output register or a dropped
//   lookup leaves the chain; adds and expired headers never stall in_i.
//   ttl below 2, a miss or an interface at or above num_interfaces yields
//   no result. out_o has one output register; a stalled receiver holds it
//   and the block can finish one more lookup behind it before in_i.ready
//   stays low. cfg_we_i writes num_interfaces (5 bits).
//   Reset empties the table (fill count zero), clears the chain tokens and
//   sets num_interfaces to 16.
// ----------------------------------------------------------------------------
`include "ipv4_lpm_forwarder_top_assert.svh"

module ipv4_lpm_forwarder_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ilf_req_if.sink                  in_i,
  ilf_rsp_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [ilf_pkg::CfgW-1:0] cfg_data_i
);
  import ilf_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q;
  logic [CfgW-1:0]  num_if_q;
  logic             start_q;

  logic [63:0]      front_q;
  logic [TtlW-1:0]  nttl_q;
  logic [7:0]       proto_q;
  logic [AddrW-1:0] src_q;
  logic [AddrW-1:0] dst_q;

  logic             acc, add_fire, route_fire, table_full;
  entry_t           new_entry;

  logic [TableDepth:0] tok_v;
  best_t               best_v [TableDepth+1];

  logic             tok_out, route_ok, load;
  best_t            best_out;
  logic [CsumW-1:0] csum;

  logic             out_vld_q;
  logic [IfW-1:0]   pend_iface_q, out_iface_q;
  logic [AddrW-1:0] pend_hop_q, out_hop_q;
  logic [TtlW-1:0]  pend_ttl_q, out_ttl_q;
  logic [CsumW-1:0] pend_csum_q, out_csum_q;

  assign in_i.ready = (state_q == StIdle);
  assign acc        = in_i.valid && in_i.ready;
  assign table_full = (count_q >= CntW'(TableDepth));
  assign add_fire   = acc && (in_i.func == FuncAdd) && !table_full;
  assign route_fire = acc && (in_i.func == FuncRoute) && (in_i.ttl > 8'd1);

  assign new_entry.prefix = in_i.add_prefix;
  assign new_entry.len    = in_i.prefix_len;
  assign new_entry.hop    = {in_i.has_gw, in_i.gw_ip};
  assign new_entry.iface  = in_i.iface_num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      num_if_q <= NumIfReset;
      start_q  <= 1'b0;
      state_q  <= StIdle;
    end else begin
      if (add_fire) begin
        count_q <= count_q + 1'b1;
      end
      if (cfg_we_i) begin
        num_if_q <= cfg_data_i;
      end
      start_q <= route_fire;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (route_fire) begin
      front_q <= in_i.hdr_front;
      nttl_q  <= in_i.ttl - 8'd1;
      proto_q <= in_i.proto;
      src_q   <= in_i.src_addr;
      dst_q   <= in_i.dest_ip;
    end
  end

  // cell chain: token enters cell 0 the cycle after the request
  assign tok_v[0]  = start_q;
  assign best_v[0] = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    logic wr, active;
    assign wr     = add_fire && (count_q[IdxW-1:0] == IdxW'(g));
    assign active = (count_q > CntW'(g));

    ilf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .entry_i  (new_entry),
      .active_i (active),
      .dst_i    (dst_q),
      .tok_i    (tok_v[g]),
      .best_i   (best_v[g]),
      .tok_o    (tok_v[g+1]),
      .best_o   (best_v[g+1])
    );
  end

  ilf_csum u_csum (
    .hdr_front_i (front_q),
    .ttl_i       (nttl_q),
    .proto_i     (proto_q),
    .src_i       (src_q),
    .dst_i       (dst_q),
    .csum_o      (csum)
  );

  assign tok_out  = tok_v[TableDepth];
  assign best_out = best_v[TableDepth];
  assign route_ok = best_out.found && ({1'b0, best_out.iface} < num_if_q)
                    && (32'(best_out.iface) < 32'(MaxIfaces));
  assign load     = (state_q == StHold) && (!out_vld_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (route_fire) begin
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (tok_out) begin
          state_d = route_ok ? StHold : StIdle;
        end
      end
      StHold: begin
        if (load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tok_out) begin
      pend_iface_q <= best_out.iface;
      pend_hop_q   <= best_out.hop[AddrW] ? best_out.hop[AddrW-1:0] : dst_q;
      pend_ttl_q   <= nttl_q;
      pend_csum_q  <= csum;
    end
    if (load) begin
      out_iface_q <= pend_iface_q;
      out_hop_q   <= pend_hop_q;
      out_ttl_q   <= pend_ttl_q;
      out_csum_q  <= pend_csum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.out_iface    = out_iface_q;
  assign out_o.fwd_ip       = out_hop_q;
  assign out_o.new_ttl      = out_ttl_q;
  assign out_o.new_checksum = out_csum_q;

  `ILF_ASSERT_IMP(a_one_token, 1'b1, $onehot0(tok_v), "more than one lookup in the chain")
  `ILF_ASSERT_IMP(a_count_max, 1'b1, count_q <= CntW'(TableDepth), "fill count past depth")
  `ILF_ASSERT_IMP(a_tok_walk, tok_out, state_q == StWalk, "lookup left chain outside walk")
  `ILF_ASSERT_NXT(a_route_start, route_fire, tok_v[0] && state_q == StWalk, "lookup not started")

endmodule

// File: rtl/core/ilf_cell.sv
// ----------------------------------------------------------------------------
// ilf_cell
// One route table entry; compares the passing lookup and forwards the best.
// ----------------------------------------------------------------------------
module ilf_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  ilf_pkg::entry_t        entry_i,
  input  logic                   active_i,
  input  logic [ilf_pkg::AddrW-1:0] dst_i,
  input  logic                   tok_i,
  input  ilf_pkg::best_t         best_i,
  output logic                   tok_o,
  output ilf_pkg::best_t         best_o
);
  import ilf_pkg::*;

  entry_t           ent_q;
  logic             tok_q;
  best_t            best_q, best_d;
  logic [AddrW-1:0] mask;
  logic             hit;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q <= entry_i;
    end
  end

  // zero-length shift gives all ones, inverted to no mask bits
  assign mask = ~({AddrW{1'b1}} >> ent_q.len);
  assign hit  = ((dst_i & mask) == (ent_q.prefix & mask));

  always_comb begin
    best_d = best_i;
    if (active_i) begin
      if (ent_q.len == '0) begin
        // default route holds only until a real prefix matched
        if (best_i.longest == '0) begin
          best_d.found = 1'b1;
          best_d.iface = ent_q.iface;
          best_d.hop   = ent_q.hop;
        end
      end else if (ent_q.len <= FullLen && hit && ent_q.len > best_i.longest) begin
        best_d.found   = 1'b1;
        best_d.longest = ent_q.len;
        best_d.iface   = ent_q.iface;
        best_d.hop     = ent_q.hop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      best_q <= best_d;
    end
  end

  assign tok_o  = tok_q;
  assign best_o = best_q;

endmodule

// File: rtl/core/ilf_csum.sv
// ----------------------------------------------------------------------------
// ilf_csum
// Ones-complement header checksum with the checksum word taken as zero.
// ----------------------------------------------------------------------------
module ilf_csum (
  input  logic [63:0]               hdr_front_i,
  input  logic [ilf_pkg::TtlW-1:0]  ttl_i,
  input  logic [7:0]                proto_i,
  input  logic [ilf_pkg::AddrW-1:0] src_i,
  input  logic [ilf_pkg::AddrW-1:0] dst_i,
  output logic [ilf_pkg::CsumW-1:0] csum_o
);
  import ilf_pkg::*;

  logic [19:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign sum = 20'(hdr_front_i[63:48]) + 20'(hdr_front_i[47:32])
             + 20'(hdr_front_i[31:16]) + 20'(hdr_front_i[15:0])
             + 20'({ttl_i, proto_i})
             + 20'(src_i[31:16]) + 20'(src_i[15:0])
             + 20'(dst_i[31:16]) + 20'(dst_i[15:0]);

  // two end-around carry folds cover a 20-bit sum
  assign fold1  = 17'(sum[15:0]) + 17'(sum[19:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign csum_o = ~fold2;

endmodule
